>>> src/bilinear_image_scaler_unit_macros.svh
// assertion helpers for the bilinear image scaler
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef BILINEAR_IMAGE_SCALER_UNIT_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_MACROS_SVH

// condition and consequence in the same cycle
`define BIS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bis_pkg.sv
// shared types and constants of the bilinear image scaler
// no dependencies; used by every module of the block but bis_ram
package bis_pkg;

    // fixed field widths
    localparam int COORD_BITS    = 12;
    localparam int DIM_BITS      = 9;
    localparam int SCALE_BITS    = 13;
    localparam int INV_BITS      = 17;
    localparam int SAMPLE_W      = 16;
    localparam int FRAC_BITS     = 16;
    localparam int OUTDIM_BITS   = 14;
    localparam int PROD_BITS     = COORD_BITS + INV_BITS;
    localparam int CHAN_BITS     = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;

    // unity magnification in q5.8
    localparam logic [SCALE_BITS-1:0] SCALE_ONE = 13'd256;

    // register reset values
    localparam logic [DIM_BITS-1:0]   DEF_SRC_WIDTH  = 9'd256;
    localparam logic [DIM_BITS-1:0]   DEF_SRC_HEIGHT = 9'd256;
    localparam logic [SCALE_BITS-1:0] DEF_SCALE      = 13'd512;
    localparam logic [INV_BITS-1:0]   DEF_INV_SCALE  = 17'd32768;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SRC_WIDTH    = 2'd0,
        CFG_SRC_HEIGHT   = 2'd1,
        CFG_SCALE_FACTOR = 2'd2,
        CFG_INV_SCALE    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FACTOR = 2'd2
    } t_status;

    // input beat
    typedef struct packed {
        logic                  func;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [CHAN_BITS-1:0]  channel;
        logic [SAMPLE_W-1:0]   sample_in;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        t_status             status;
    } t_out_beat;

    // geometry derived from the registers
    typedef struct packed {
        logic [DIM_BITS-1:0]    w_last;
        logic [DIM_BITS-1:0]    h_last;
        logic [OUTDIM_BITS-1:0] out_w;
        logic [OUTDIM_BITS-1:0] out_h;
        logic [SCALE_BITS-1:0]  scale;
        logic [INV_BITS-1:0]    inv;
    } t_geom;

    // front end result, ready for the frame store
    typedef struct packed {
        logic                  valid;
        logic                  is_rd;
        t_status               status;
        logic [CHAN_BITS-1:0]  channel;
        logic [DIM_BITS-1:0]   x0;
        logic [DIM_BITS-1:0]   x1;
        logic [DIM_BITS-1:0]   y0;
        logic [DIM_BITS-1:0]   y1;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic                  wr_en;
        logic [COORD_BITS-1:0] wr_x;
        logic [COORD_BITS-1:0] wr_y;
        logic [SAMPLE_W-1:0]   wr_sample;
    } t_fe;

    // read in flight beside the bank outputs
    typedef struct packed {
        logic                 valid;
        t_status              status;
        logic                 x0p;
        logic                 x1p;
        logic                 y0p;
        logic                 y1p;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } t_mid;

endpackage

>>> src/bis_ram.sv
// generic single write port ram with registered read
// no dependencies
module bis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bis_front.sv
// front end: input register, source position multiply, status, edge clamp
// depends on bis_pkg
module bis_front #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_take,
    input  bis_pkg::t_in_beat i_beat,
    input  bis_pkg::t_geom   i_geom,
    output bis_pkg::t_fe     o_stage
);

    localparam int LIM_BITS = bis_pkg::COORD_BITS + 1;
    localparam logic [LIM_BITS-1:0] W_LIM = LIM_BITS'(MAX_WIDTH);
    localparam logic [LIM_BITS-1:0] H_LIM = LIM_BITS'(MAX_HEIGHT);
    localparam int CLIM_BITS = bis_pkg::CHAN_BITS + 1;
    localparam logic [CLIM_BITS-1:0] C_LIM = CLIM_BITS'(MAX_CHANNELS);
    localparam int XR_BITS = bis_pkg::PROD_BITS - bis_pkg::FRAC_BITS;

    // stage 0: accepted beat
    logic              r0_valid;
    bis_pkg::t_in_beat r0_beat;

    // stage 1: products and checks
    logic                              r1_valid;
    logic                              r1_is_rd;
    bis_pkg::t_status                  r1_status;
    logic [bis_pkg::CHAN_BITS-1:0]     r1_ch;
    logic [bis_pkg::PROD_BITS-1:0]     r1_sx;
    logic [bis_pkg::PROD_BITS-1:0]     r1_sy;
    logic                              r1_wr_en;
    logic [bis_pkg::COORD_BITS-1:0]    r1_wr_x;
    logic [bis_pkg::COORD_BITS-1:0]    r1_wr_y;
    logic [bis_pkg::SAMPLE_W-1:0]      r1_sample;

    logic [bis_pkg::PROD_BITS-1:0] n1_sx;
    logic [bis_pkg::PROD_BITS-1:0] n1_sy;
    bis_pkg::t_status              n1_status;
    logic                          n1_wr_en;
    logic                          n1_ch_ok;

    // stage 2: clamped neighbours
    bis_pkg::t_fe r2_stage;
    bis_pkg::t_fe n2_stage;

    logic [XR_BITS-1:0] w_x0_raw;
    logic [XR_BITS-1:0] w_y0_raw;
    logic [XR_BITS:0]   w_x1_raw;
    logic [XR_BITS:0]   w_y1_raw;

    // stage 0 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_beat <= i_beat;
        end
    end

    // source position and status checks
    always_comb begin
        n1_sx    = r0_beat.pos_x * i_geom.inv;
        n1_sy    = r0_beat.pos_y * i_geom.inv;
        n1_ch_ok = {1'b0, r0_beat.channel} < C_LIM;
        n1_wr_en = (r0_beat.func == bis_pkg::FUNC_WRITE) && n1_ch_ok
                   && ({1'b0, r0_beat.pos_x} < W_LIM) && ({1'b0, r0_beat.pos_y} < H_LIM);
        priority if (i_geom.scale < bis_pkg::SCALE_ONE) begin
            n1_status = bis_pkg::ST_FACTOR;
        end else if (({2'b00, r0_beat.pos_x} >= i_geom.out_w)
                     || ({2'b00, r0_beat.pos_y} >= i_geom.out_h) || !n1_ch_ok) begin
            n1_status = bis_pkg::ST_RANGE;
        end else begin
            n1_status = bis_pkg::ST_OK;
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_is_rd  <= (r0_beat.func == bis_pkg::FUNC_READ);
            r1_status <= n1_status;
            r1_ch     <= r0_beat.channel;
            r1_sx     <= n1_sx;
            r1_sy     <= n1_sy;
            r1_wr_en  <= n1_wr_en;
            r1_wr_x   <= r0_beat.pos_x;
            r1_wr_y   <= r0_beat.pos_y;
            r1_sample <= r0_beat.sample_in;
        end
    end

    // clamp neighbour coordinates to the image edges
    always_comb begin
        w_x0_raw = r1_sx[bis_pkg::PROD_BITS-1:bis_pkg::FRAC_BITS];
        w_y0_raw = r1_sy[bis_pkg::PROD_BITS-1:bis_pkg::FRAC_BITS];
        w_x1_raw = {1'b0, w_x0_raw} + 1'b1;
        w_y1_raw = {1'b0, w_y0_raw} + 1'b1;

        n2_stage           = '0;
        n2_stage.valid     = r1_valid;
        n2_stage.is_rd     = r1_is_rd;
        n2_stage.status    = r1_status;
        n2_stage.channel   = r1_ch;
        n2_stage.fx        = r1_sx[bis_pkg::FRAC_BITS-1:0];
        n2_stage.fy        = r1_sy[bis_pkg::FRAC_BITS-1:0];
        n2_stage.wr_en     = r1_wr_en;
        n2_stage.wr_x      = r1_wr_x;
        n2_stage.wr_y      = r1_wr_y;
        n2_stage.wr_sample = r1_sample;
        n2_stage.x0 = (w_x0_raw > XR_BITS'(i_geom.w_last)) ? i_geom.w_last
                                                          : w_x0_raw[bis_pkg::DIM_BITS-1:0];
        n2_stage.x1 = (w_x1_raw > (XR_BITS + 1)'(i_geom.w_last)) ? i_geom.w_last
                                                                : w_x1_raw[bis_pkg::DIM_BITS-1:0];
        n2_stage.y0 = (w_y0_raw > XR_BITS'(i_geom.h_last)) ? i_geom.h_last
                                                          : w_y0_raw[bis_pkg::DIM_BITS-1:0];
        n2_stage.y1 = (w_y1_raw > (XR_BITS + 1)'(i_geom.h_last)) ? i_geom.h_last
                                                                : w_y1_raw[bis_pkg::DIM_BITS-1:0];
    end

    // stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_stage <= '0;
        end else if (i_en) begin
            r2_stage <= n2_stage;
        end
    end

    assign o_stage = r2_stage;

endmodule

>>> src/bis_blend.sv
// blend unit: horizontal lerp, split vertical multiply, final sum and truncate
// depends on bis_pkg
module bis_blend (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  bis_pkg::t_mid                         i_mid,
    input  logic [3:0][bis_pkg::SAMPLE_W-1:0]     i_q,
    output logic                                  o_push,
    output bis_pkg::t_out_beat                    o_beat
);

    // neighbour select, bank index is {y parity, x parity}
    logic [bis_pkg::SAMPLE_W-1:0] w_s00;
    logic [bis_pkg::SAMPLE_W-1:0] w_s10;
    logic [bis_pkg::SAMPLE_W-1:0] w_s01;
    logic [bis_pkg::SAMPLE_W-1:0] w_s11;

    logic signed [16:0] w_dt;
    logic signed [16:0] w_db;
    logic signed [33:0] w_pt;
    logic signed [33:0] w_pb;
    logic signed [33:0] w_top;
    logic signed [33:0] w_bot;

    // stage 4
    logic                          r4_valid;
    bis_pkg::t_status              r4_status;
    logic [bis_pkg::FRAC_BITS-1:0] r4_fy;
    logic [31:0]                   r4_top;
    logic [31:0]                   r4_bot;

    logic signed [32:0] w_d;
    logic        [31:0] w_pl;
    logic signed [33:0] w_ph;

    // stage 5
    logic                 r5_valid;
    bis_pkg::t_status     r5_status;
    logic [31:0]          r5_top;
    logic [31:0]          r5_pl;
    logic signed [33:0]   r5_ph;

    logic signed [49:0]   w_acc;

    // horizontal blend: s0 * 2^16 + fx * (s1 - s0)
    always_comb begin
        w_s00 = i_q[{i_mid.y0p, i_mid.x0p}];
        w_s10 = i_q[{i_mid.y0p, i_mid.x1p}];
        w_s01 = i_q[{i_mid.y1p, i_mid.x0p}];
        w_s11 = i_q[{i_mid.y1p, i_mid.x1p}];
        w_dt  = $signed({1'b0, w_s10}) - $signed({1'b0, w_s00});
        w_db  = $signed({1'b0, w_s11}) - $signed({1'b0, w_s01});
        w_pt  = $signed({1'b0, i_mid.fx}) * w_dt;
        w_pb  = $signed({1'b0, i_mid.fx}) * w_db;
        w_top = $signed({2'b00, w_s00, 16'h0000}) + w_pt;
        w_bot = $signed({2'b00, w_s01, 16'h0000}) + w_pb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_mid.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_status <= i_mid.status;
            r4_fy     <= i_mid.fy;
            r4_top    <= w_top[31:0];
            r4_bot    <= w_bot[31:0];
        end
    end

    // vertical blend, fy * (bot - top) split into low and high partial products
    always_comb begin
        w_d  = $signed({1'b0, r4_bot}) - $signed({1'b0, r4_top});
        w_pl = r4_fy * w_d[15:0];
        w_ph = $signed({1'b0, r4_fy}) * $signed(w_d[32:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_status <= r4_status;
            r5_top    <= r4_top;
            r5_pl     <= w_pl;
            r5_ph     <= w_ph;
        end
    end

    // exact sum, truncated once
    always_comb begin
        w_acc = $signed({2'b00, r5_top, 16'h0000}) + $signed({r5_ph, 16'h0000})
                + $signed({18'd0, r5_pl});
        o_beat.status     = r5_status;
        o_beat.sample_out = (r5_status == bis_pkg::ST_OK) ? w_acc[47:32] : '0;
    end

    assign o_push = i_en && r5_valid;

endmodule

>>> src/bis_obuf.sv
// two-entry output buffer: output register plus skid entry
// depends on bis_pkg
module bis_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bis_pkg::t_out_beat i_beat,
    input  logic               i_stall,
    output logic               o_valid,
    output bis_pkg::t_out_beat o_beat,
    output logic               o_full
);

    logic               r_main_valid;
    bis_pkg::t_out_beat r_main;
    logic               r_skid_valid;
    bis_pkg::t_out_beat r_skid;
    logic               w_free;

    // main register can load when empty or when its beat leaves
    assign w_free = !r_main_valid || !i_stall;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_main <= r_skid_valid ? r_skid : i_beat;
        end else if (i_push) begin
            r_skid <= i_beat;
        end
    end

    assign o_valid = r_main_valid;
    assign o_beat  = r_main;
    assign o_full  = r_skid_valid;

endmodule

>>> src/bilinear_image_scaler_unit.sv
// top level of the bilinear image scaler: registers, banked frame store, pipeline
// depends on bis_pkg, bis_ram, bis_front, bis_blend, bis_obuf and the macro header
//
// usage
//   input channel i_in_valid / o_in_stall / i_in_data carries write and read beats.
//   a write beat stores one source sample and gives no result; a read beat asks for
//   one sample of the magnified image and gives exactly one output beat on
//   o_out_valid / i_out_stall / o_out_data, in input order.
//   registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// pipeline and throughput
//   a read passes the front end, bank read and r_mid, blend registers and output
//   register in order; one beat of either kind is taken every cycle while o_in_stall
//   is low. the frame store is four banks interleaved by x and y parity, each with
//   one write and one read port, so a read's four neighbours come out together.
// reset
//   control state clears and the registers take their defaults; the frame store
//   holds no defined data until written and needs no clearing pass.
// stall
//   a two-entry output buffer parts the sides; o_in_stall rises only once both
//   entries hold a result that the receiver has not taken.
`include "bilinear_image_scaler_unit_macros.svh"

module bilinear_image_scaler_unit #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 3,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bis_pkg::t_in_beat                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bis_pkg::t_out_beat                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int STORE_BITS = (SAMPLE_BITS < bis_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : bis_pkg::SAMPLE_W;
    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H * MAX_CHANNELS;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LIM_BITS   = bis_pkg::DIM_BITS + 4;
    localparam logic [LIM_BITS-1:0] W_LIM = LIM_BITS'(MAX_WIDTH);
    localparam logic [LIM_BITS-1:0] H_LIM = LIM_BITS'(MAX_HEIGHT);
    localparam int SPROD_BITS = bis_pkg::DIM_BITS + bis_pkg::SCALE_BITS;

    // configuration registers
    logic [bis_pkg::DIM_BITS-1:0]   r_src_width;
    logic [bis_pkg::DIM_BITS-1:0]   r_src_height;
    logic [bis_pkg::SCALE_BITS-1:0] r_scale;
    logic [bis_pkg::INV_BITS-1:0]   r_inv;

    // derived geometry
    logic [bis_pkg::DIM_BITS-1:0] w_eff_w;
    logic [bis_pkg::DIM_BITS-1:0] w_eff_h;
    logic [SPROD_BITS-1:0]        w_wprod;
    logic [SPROD_BITS-1:0]        w_hprod;
    bis_pkg::t_geom               n_geom;
    bis_pkg::t_geom               r_geom;

    // pipeline control
    logic               w_en;
    logic               w_take;
    logic               w_obuf_full;
    bis_pkg::t_fe       w_fe;
    bis_pkg::t_mid      r_mid;
    bis_pkg::t_mid      n_mid;
    logic               w_push;
    bis_pkg::t_out_beat w_push_beat;
    logic               w_push_err;

    // frame store banks
    logic [3:0]                         w_bank_we;
    logic [3:0][STORE_BITS-1:0]         w_bank_q;
    logic [3:0][bis_pkg::SAMPLE_W-1:0]  w_q_ext;
    logic [31:0]                        w_waddr_full;
    logic [AW-1:0]                      w_waddr;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bis_pkg::DEF_SRC_WIDTH;
            r_src_height <= bis_pkg::DEF_SRC_HEIGHT;
            r_scale      <= bis_pkg::DEF_SCALE;
            r_inv        <= bis_pkg::DEF_INV_SCALE;
        end else if (i_cfg_we) begin
            unique case (bis_pkg::t_cfg_idx'(i_cfg_idx))
                bis_pkg::CFG_SRC_WIDTH:    r_src_width  <= i_cfg_data[bis_pkg::DIM_BITS-1:0];
                bis_pkg::CFG_SRC_HEIGHT:   r_src_height <= i_cfg_data[bis_pkg::DIM_BITS-1:0];
                bis_pkg::CFG_SCALE_FACTOR: r_scale      <= i_cfg_data[bis_pkg::SCALE_BITS-1:0];
                bis_pkg::CFG_INV_SCALE:    r_inv        <= i_cfg_data[bis_pkg::INV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective size and scaled output size
    always_comb begin
        priority if (r_src_width == '0) begin
            w_eff_w = bis_pkg::DIM_BITS'(1);
        end else if ({4'd0, r_src_width} > W_LIM) begin
            w_eff_w = W_LIM[bis_pkg::DIM_BITS-1:0];
        end else begin
            w_eff_w = r_src_width;
        end
        priority if (r_src_height == '0) begin
            w_eff_h = bis_pkg::DIM_BITS'(1);
        end else if ({4'd0, r_src_height} > H_LIM) begin
            w_eff_h = H_LIM[bis_pkg::DIM_BITS-1:0];
        end else begin
            w_eff_h = r_src_height;
        end
        w_wprod       = w_eff_w * r_scale;
        w_hprod       = w_eff_h * r_scale;
        n_geom.w_last = w_eff_w - 1'b1;
        n_geom.h_last = w_eff_h - 1'b1;
        n_geom.out_w  = w_wprod[SPROD_BITS-1:8];
        n_geom.out_h  = w_hprod[SPROD_BITS-1:8];
        n_geom.scale  = r_scale;
        n_geom.inv    = r_inv;
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    // handshake and global advance
    assign w_en       = !w_obuf_full;
    assign o_in_stall = w_obuf_full;
    assign w_take     = i_in_valid && !o_in_stall;

    bis_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_take  (w_take),
        .i_beat  (i_in_data),
        .i_geom  (r_geom),
        .o_stage (w_fe)
    );

    // write address, shared by all banks
    always_comb begin
        w_waddr_full = (32'(w_fe.wr_y[bis_pkg::COORD_BITS-1:1]) * 32'(HALF_W)
                        + 32'(w_fe.wr_x[bis_pkg::COORD_BITS-1:1])) * 32'(MAX_CHANNELS)
                       + 32'(w_fe.channel);
        w_waddr = w_waddr_full[AW-1:0];
    end

    // banks by x and y parity; each reads the neighbour of its parity
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        localparam bit BX = (gb % 2) == 1;
        localparam bit BY = (gb / 2) == 1;

        logic [bis_pkg::DIM_BITS-1:0] w_xs;
        logic [bis_pkg::DIM_BITS-1:0] w_ys;
        logic [31:0]                  w_raddr_full;
        logic [AW-1:0]                w_raddr;

        always_comb begin
            w_xs = (w_fe.x0[0] == BX) ? w_fe.x0 : w_fe.x1;
            w_ys = (w_fe.y0[0] == BY) ? w_fe.y0 : w_fe.y1;
            w_raddr_full = (32'(w_ys[bis_pkg::DIM_BITS-1:1]) * 32'(HALF_W)
                            + 32'(w_xs[bis_pkg::DIM_BITS-1:1])) * 32'(MAX_CHANNELS)
                           + 32'(w_fe.channel);
            w_raddr = w_raddr_full[AW-1:0];
        end

        assign w_bank_we[gb] = w_en && w_fe.valid && w_fe.wr_en
                               && (w_fe.wr_x[0] == BX) && (w_fe.wr_y[0] == BY);

        bis_ram #(
            .WIDTH (STORE_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_bank_we[gb]),
            .i_waddr (w_waddr),
            .i_wdata (w_fe.wr_sample[STORE_BITS-1:0]),
            .i_re    (w_en),
            .i_raddr (w_raddr),
            .o_rdata (w_bank_q[gb])
        );

        assign w_q_ext[gb] = bis_pkg::SAMPLE_W'(w_bank_q[gb]);
    end

    // read info aligned with the bank outputs
    always_comb begin
        n_mid.valid  = w_fe.valid && w_fe.is_rd;
        n_mid.status = w_fe.status;
        n_mid.x0p    = w_fe.x0[0];
        n_mid.x1p    = w_fe.x1[0];
        n_mid.y0p    = w_fe.y0[0];
        n_mid.y1p    = w_fe.y1[0];
        n_mid.fx     = w_fe.fx;
        n_mid.fy     = w_fe.fy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= '0;
        end else if (w_en) begin
            r_mid <= n_mid;
        end
    end

    bis_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_mid   (r_mid),
        .i_q     (w_q_ext),
        .o_push  (w_push),
        .o_beat  (w_push_beat)
    );

    bis_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_beat  (w_push_beat),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data),
        .o_full  (w_obuf_full)
    );

    // error beat entering the output buffer
    assign w_push_err = w_push && (w_push_beat.status != bis_pkg::ST_OK);

    // checks
    `BIS_ASSERT_SAME(a_stall_has_beat, o_in_stall, o_out_valid, "stall with no held beat")
    `BIS_ASSERT_SAME(a_one_bank_write, 1'b1, $onehot0(w_bank_we), "more than one bank written")
    `BIS_ASSERT_SAME(a_error_zero, w_push_err, w_push_beat.sample_out == '0, "error beat with data")
    `BIS_ASSERT_NEXT(a_freeze_holds, !w_en, $stable(r_mid.valid), "pipeline moved while frozen")

endmodule

>>> tb/tb_bilinear_image_scaler_unit.sv
// self-checking testbench for bilinear_image_scaler_unit: frame store writes, magnified reads
// depends on bis_pkg and the scaler top level; predicts every read result in the bench itself
module tb_bilinear_image_scaler_unit;
    import bis_pkg::*;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int NUM_CH      = 3;
    localparam int STORE_DEPTH = MAX_W * MAX_H * NUM_CH;
    localparam int SETTLE_PAD  = 12;
    localparam int DRAIN_LIMIT = 4000;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 165;

    // receiver stall patterns
    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_LIGHT  = 2'd1;
    localparam logic [1:0] STALL_HEAVY  = 2'd2;
    localparam logic [1:0] STALL_BLOCKS = 2'd3;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_beat                 i_in_data  = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_beat                o_out_data;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // register shadow copy
    logic [DIM_BITS-1:0]   cfg_w     = DEF_SRC_WIDTH;
    logic [DIM_BITS-1:0]   cfg_h     = DEF_SRC_HEIGHT;
    logic [SCALE_BITS-1:0] cfg_scale = DEF_SCALE;
    logic [INV_BITS-1:0]   cfg_inv   = DEF_INV_SCALE;

    // source image copy and which entries hold data
    logic [SAMPLE_W-1:0] src_mem  [STORE_DEPTH];
    bit                  src_seen [STORE_DEPTH];

    t_out_beat   pending_pixels[$];
    int unsigned mismatch_cnt = 0;
    int unsigned beats_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned status_cnt [3] = '{0, 0, 0};
    int unsigned cfg_sets     = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned burst_left   = 1;
    bit          gaps_on      = 1'b1;
    logic [1:0]  stall_mode   = STALL_NONE;
    int unsigned stall_run    = 0;

    bilinear_image_scaler_unit #(
        .MAX_WIDTH   (MAX_W),
        .MAX_HEIGHT  (MAX_H),
        .MAX_CHANNELS(NUM_CH),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results pending", $time,
                     pending_pixels.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned eff_dim(logic [DIM_BITS-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic int unsigned out_dim(logic [DIM_BITS-1:0] v, int unsigned lim);
        return (eff_dim(v, lim) * int'(cfg_scale)) >> 8;
    endfunction

    function automatic int unsigned store_index(int unsigned x, int unsigned y,
                                                int unsigned ch);
        return (y * MAX_W + x) * NUM_CH + ch;
    endfunction

    function automatic logic [SAMPLE_W-1:0] src_pix(int unsigned x, int unsigned y,
                                                    int unsigned ch);
        return src_mem[store_index(x, y, ch)];
    endfunction

    // writes outside the store or to a missing channel leave no trace
    function automatic bit is_dropped(t_in_beat b);
        return b.func == FUNC_WRITE &&
               (b.pos_x >= MAX_W || b.pos_y >= MAX_H || b.channel >= NUM_CH);
    endfunction

    // factor check wins over the coordinate and channel checks
    function automatic t_status read_status(t_in_beat b);
        if (cfg_scale < SCALE_ONE) return ST_FACTOR;
        if (b.pos_x >= out_dim(cfg_w, MAX_W) || b.pos_y >= out_dim(cfg_h, MAX_H) ||
            b.channel >= NUM_CH)
            return ST_RANGE;
        return ST_OK;
    endfunction

    // source position in q16, neighbours clamped to the last row and column
    function automatic void calc_taps(input logic [COORD_BITS-1:0] px, py,
                                      output int unsigned x0, x1, y0, y1,
                                      output logic [FRAC_BITS-1:0] fx, fy);
        int unsigned w_last;
        int unsigned h_last;
        logic [63:0] sx;
        logic [63:0] sy;
        w_last = eff_dim(cfg_w, MAX_W) - 1;
        h_last = eff_dim(cfg_h, MAX_H) - 1;
        sx = 64'(px) * 64'(cfg_inv);
        sy = 64'(py) * 64'(cfg_inv);
        fx = sx[15:0];
        fy = sy[15:0];
        sx = sx >> 16;
        sy = sy >> 16;
        x0 = (sx > w_last) ? w_last : 32'(sx);
        x1 = (sx + 1 > w_last) ? w_last : 32'(sx + 1);
        y0 = (sy > h_last) ? h_last : 32'(sy);
        y1 = (sy + 1 > h_last) ? h_last : 32'(sy + 1);
    endfunction

    // exact blend of the four neighbours, truncated once
    function automatic t_out_beat predict_pixel(t_in_beat b);
        t_out_beat r;
        int unsigned x0, x1, y0, y1;
        logic [FRAC_BITS-1:0] fx, fy;
        logic [63:0] wx0, wy0, top, bot, acc;
        r.status = read_status(b);
        r.sample_out = '0;
        if (r.status == ST_OK) begin
            calc_taps(b.pos_x, b.pos_y, x0, x1, y0, y1, fx, fy);
            wx0 = 64'd65536 - 64'(fx);
            wy0 = 64'd65536 - 64'(fy);
            top = wx0 * 64'(src_pix(x0, y0, b.channel)) +
                  64'(fx) * 64'(src_pix(x1, y0, b.channel));
            bot = wx0 * 64'(src_pix(x0, y1, b.channel)) +
                  64'(fx) * 64'(src_pix(x1, y1, b.channel));
            acc = wy0 * top + 64'(fy) * bot;
            r.sample_out = acc[47:32];
        end
        return r;
    endfunction

    function automatic void apply_beat(t_in_beat b);
        int unsigned idx;
        if (b.func == FUNC_READ) begin
            pending_pixels.insert(pending_pixels.size(), predict_pixel(b));
        end else if (!is_dropped(b)) begin
            idx = store_index(b.pos_x, b.pos_y, b.channel);
            src_mem[idx]  = b.sample_in;
            src_seen[idx] = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: result with nothing expected, got sample %h status %0d",
                         $time, o_out_data.sample_out, o_out_data.status);
                mismatch_cnt++;
            end else begin
                want = pending_pixels.pop_front();
                results_seen++;
                status_cnt[want.status]++;
                if (o_out_data.sample_out !== want.sample_out) begin
                    $display("%0t: sample_out mismatch, expected %h got %h", $time,
                             want.sample_out, o_out_data.sample_out);
                    mismatch_cnt++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d got %0d", $time,
                             want.status, o_out_data.status);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver stall pattern, picked at random and redrawn when its run ends
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_run  <= $urandom_range(32, 200);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 1) == 0);
            STALL_BLOCKS: i_out_stall <= (stall_run[4:3] == 2'b11);
            default:      i_out_stall <= 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- sender side

    task automatic hold_off(int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // one beat, held until taken, then the burst bookkeeping
    task automatic push_beat(t_in_beat b);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        apply_beat(b);
        if (!is_dropped(b)) beats_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) hold_off($urandom_range(1, 6));
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_sample(int unsigned x, int unsigned y, int unsigned ch,
                                logic [SAMPLE_W-1:0] smp);
        t_in_beat b;
        b.func      = FUNC_WRITE;
        b.pos_x     = COORD_BITS'(x);
        b.pos_y     = COORD_BITS'(y);
        b.channel   = CHAN_BITS'(ch);
        b.sample_in = smp;
        push_beat(b);
    endtask

    task automatic seed_source(int unsigned x, int unsigned y, int unsigned ch);
        if (!src_seen[store_index(x, y, ch)]) write_sample(x, y, ch, rand_sample());
    endtask

    // a read, preceded by writes for any neighbour not yet stored
    task automatic read_px(int unsigned x, int unsigned y, int unsigned ch);
        t_in_beat b;
        int unsigned x0, x1, y0, y1;
        logic [FRAC_BITS-1:0] fx, fy;
        b.func      = FUNC_READ;
        b.pos_x     = COORD_BITS'(x);
        b.pos_y     = COORD_BITS'(y);
        b.channel   = CHAN_BITS'(ch);
        b.sample_in = SAMPLE_W'($urandom_range(0, 65535));
        if (read_status(b) == ST_OK) begin
            calc_taps(b.pos_x, b.pos_y, x0, x1, y0, y1, fx, fy);
            seed_source(x0, y0, ch);
            seed_source(x1, y0, ch);
            seed_source(x0, y1, ch);
            seed_source(x1, y1, ch);
        end
        push_beat(b);
    endtask

    // stop sending until every result is in, then optionally let writes drain
    task automatic settle(int unsigned pad);
        int unsigned k;
        hold_off(1);
        for (k = 0; k < DRAIN_LIMIT && pending_pixels.size() != 0; k++) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_pixels.size());
            mismatch_cnt++;
            pending_pixels.delete();
        end
        repeat (pad) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SRC_WIDTH:    cfg_w     = val[DIM_BITS-1:0];
            CFG_SRC_HEIGHT:   cfg_h     = val[DIM_BITS-1:0];
            CFG_SCALE_FACTOR: cfg_scale = val[SCALE_BITS-1:0];
            CFG_INV_SCALE:    cfg_inv   = val[INV_BITS-1:0];
        endcase
    endtask

    // all four registers, only once the pipeline is empty
    task automatic reconfigure(logic [CFG_DATA_BITS-1:0] w, h, scale, inv);
        settle(SETTLE_PAD);
        put_reg(CFG_SRC_WIDTH, w);
        put_reg(CFG_SRC_HEIGHT, h);
        put_reg(CFG_SCALE_FACTOR, scale);
        put_reg(CFG_INV_SCALE, inv);
        i_cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    // ---------------------------------------------------------------- tests

    // default registers: extreme samples and corners, ignored writes, range errors
    task automatic test_store_extremes();
        gaps_on = 1'b1;
        write_sample(0, 0, 0, 16'h0000);
        write_sample(1, 0, 0, 16'hFFFF);
        write_sample(0, 1, 0, 16'hFFFF);
        write_sample(1, 1, 0, 16'h0000);
        write_sample(255, 255, 2, 16'hFFFF);
        write_sample(4095, 0, 0, 16'h1234);
        write_sample(0, 4095, 1, 16'h5678);
        write_sample(3, 3, 3, 16'h9ABC);
        read_px(0, 0, 0);
        read_px(1, 1, 0);
        read_px(511, 511, 2);
        read_px(512, 0, 0);
        read_px(0, 512, 1);
        read_px(0, 0, 3);
        read_px(4095, 4095, 0);
    endtask

    // magnification below one, checked ahead of everything else
    task automatic test_factor_below_one();
        reconfigure(256, 256, 255, 32768);
        read_px(0, 0, 0);
        read_px(4095, 4095, 3);
        reconfigure(256, 256, 0, 32768);
        read_px(10, 10, 1);
    endtask

    // zero and oversized dimensions, largest factor, reciprocal at both ends
    task automatic test_register_extremes();
        reconfigure(0, 0, 256, 65536);
        read_px(0, 0, 1);
        read_px(1, 0, 1);
        write_sample(5, 5, 1, 16'hA5A5);
        reconfigure(511, 300, 8191, 0);
        read_px(4095, 4095, 0);
        reconfigure(2, 2, 4096, 131071);
        read_px(31, 31, 0);
        reconfigure(256, 256, 256, 1);
        read_px(255, 255, 0);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 256;
            4:       return $urandom_range(257, 511);
            5:       return $urandom_range(25, 255);
            default: return $urandom_range(2, 24);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0:       return 256;
            1:       return 4096;
            2:       return 8191;
            3:       return $urandom_range(4097, 8191);
            default: return $urandom_range(257, 2048);
        endcase
    endfunction

    // mostly scan lines and single reads over a random source, some stray traffic
    task automatic test_random_traffic();
        logic [CFG_DATA_BITS-1:0] w, h, scale, inv;
        int unsigned phase, start, pick, ow, oh, x, y, ch, len, k;
        t_in_beat b;
        bit paused;
        for (phase = 0; phase < PHASES; phase++) begin
            w     = pick_dim();
            h     = pick_dim();
            scale = pick_scale();
            case ($urandom_range(0, 5))
                0:       inv = $urandom_range(0, 131071);
                default: inv = (1 << 24) / scale;
            endcase
            reconfigure(w, h, scale, inv);
            gaps_on = ($urandom_range(0, 2) != 0);
            ow = out_dim(cfg_w, MAX_W);
            oh = out_dim(cfg_h, MAX_H);
            if (ow > 4096) ow = 4096;
            if (oh > 4096) oh = 4096;
            start  = beats_sent;
            paused = 1'b0;
            while (beats_sent - start < PHASE_BEATS) begin
                if (!paused && beats_sent - start >= PHASE_BEATS / 2) begin
                    settle(0);
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    read_px($urandom_range(0, ow - 1), $urandom_range(0, oh - 1),
                            $urandom_range(0, NUM_CH - 1));
                end else if (pick < 60) begin
                    read_px($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 3));
                end else if (pick < 75) begin
                    write_sample($urandom_range(0, eff_dim(cfg_w, MAX_W) - 1),
                                 $urandom_range(0, eff_dim(cfg_h, MAX_H) - 1),
                                 $urandom_range(0, NUM_CH - 1), rand_sample());
                end else if (pick < 85) begin
                    // stray writes, inside the store or anywhere
                    b.func      = FUNC_WRITE;
                    b.pos_x     = COORD_BITS'($urandom_range(0, 4095));
                    b.pos_y     = COORD_BITS'($urandom_range(0, 4095));
                    if ($urandom_range(0, 1) == 0) begin
                        b.pos_x = b.pos_x % MAX_W;
                        b.pos_y = b.pos_y % MAX_H;
                    end
                    b.channel   = CHAN_BITS'($urandom_range(0, 3));
                    b.sample_in = rand_sample();
                    push_beat(b);
                end else if (pick < 97) begin
                    // short scan along one output line
                    y   = $urandom_range(0, oh - 1);
                    ch  = $urandom_range(0, NUM_CH - 1);
                    x   = $urandom_range(0, ow - 1);
                    len = $urandom_range(4, 16);
                    for (k = 0; k < len && x + k < ow; k++) read_px(x + k, y, ch);
                end else begin
                    settle(0);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_extremes();
        test_factor_below_one();
        test_register_extremes();
        test_random_traffic();
        settle(SETTLE_PAD);
        $display("run covered %0d stored or read beats over %0d register settings",
                 beats_sent, cfg_sets);
        $display("checked %0d results: %0d ok, %0d out of range, %0d factor below one",
                 results_seen, status_cnt[ST_OK], status_cnt[ST_RANGE],
                 status_cnt[ST_FACTOR]);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
